/* sv/fdmt_pkg.sv */
// Shared types and constants for the fan duty from maximum temperature block.
// Used by every module of the block; depends on nothing.
package fdmt_pkg;

    localparam int TEMP_W  = 16;
    localparam int DUTY_W  = 10;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

    // Interpolation: quotient of 800*span/den, always below 800.
    localparam int QUO_W   = 10;
    localparam int SPAN_W  = 16;
    localparam int DIVD_W  = SPAN_W + QUO_W;
    localparam int DIV_STEPS = QUO_W;
    localparam int STEP_W  = $clog2(DIV_STEPS);

    localparam logic signed [TEMP_W-1:0] TEMP_FLOOR = -16'sd4368;
    localparam logic signed [TEMP_W-1:0] LOW_RESET  = 16'sd640;
    localparam logic signed [TEMP_W-1:0] HIGH_RESET = 16'sd1280;
    localparam logic [DUTY_W-1:0] DUTY_MIN  = 10'd200;
    localparam logic [DUTY_W-1:0] DUTY_MAX  = 10'd1000;
    localparam logic [DUTY_W-1:0] DUTY_SPAN = 10'd800;

    typedef enum logic [0:0] {
        REG_TEMP_LOW  = 1'b0,
        REG_TEMP_HIGH = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic                     frame_last;
    } sample_t;

    typedef struct packed {
        logic        [DUTY_W-1:0] duty_permille;
        logic signed [TEMP_W-1:0] max_temperature;
    } result_t;

    // One frame maximum moving between front, queue and back.
    typedef struct packed {
        logic                     valid;
        logic signed [TEMP_W-1:0] peak;
    } frame_max_t;

endpackage

/* sv/fdmt_front.sv */
// Front part: accepts temperature samples and keeps the running frame maximum.
// Depends on fdmt_pkg; pushes each finished frame maximum toward the queue.
module fdmt_front
    import fdmt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       sample_valid,
    input  logic       sample_stall,
    input  sample_t    sample,
    output frame_max_t push
);

    logic signed [TEMP_W-1:0] running_max_reg;
    logic signed [TEMP_W-1:0] running_max_next;
    logic signed [TEMP_W-1:0] frame_max;
    logic                     accept;

    assign accept    = sample_valid && !sample_stall;
    assign frame_max = (sample.temperature > running_max_reg) ? sample.temperature
                                                              : running_max_reg;

    always_comb
    begin
        running_max_next = running_max_reg;
        if (accept)
        begin
            // restart the maximum after the last sample of a frame
            running_max_next = sample.frame_last ? TEMP_FLOOR : frame_max;
        end
    end

    assign push.valid = accept && sample.frame_last;
    assign push.peak  = frame_max;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_max_reg <= TEMP_FLOOR;
        end
        else
        begin
            running_max_reg <= running_max_next;
        end
    end

endmodule

/* sv/fdmt_queue.sv */
// Short queue of frame maxima between the front and back parts.
// Depends on fdmt_pkg.
module fdmt_queue
    import fdmt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  frame_max_t push,
    input  logic       pop,
    output frame_max_t head,
    output logic       full
);

    logic signed [TEMP_W-1:0] entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign do_push  = push.valid && !full;
    assign do_pop   = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.peak  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.peak;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_push_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> !full)
        else $error("frame maximum pushed into full queue");

endmodule

/* sv/fdmt_back.sv */
// Back part: turns a frame maximum into a duty cycle and holds the result item.
// Depends on fdmt_pkg; interpolates with a restoring divider, one bit per cycle.
module fdmt_back
    import fdmt_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  frame_max_t               head,
    output logic                     pop,
    input  logic signed [TEMP_W-1:0] temp_low,
    input  logic signed [TEMP_W-1:0] temp_high,
    output logic                     result_valid,
    input  logic                     result_stall,
    output result_t                  result
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } back_state_t;

    back_state_t              state_reg;
    back_state_t              state_next;
    logic signed [TEMP_W-1:0] max_reg;
    logic signed [TEMP_W-1:0] max_next;
    logic [SPAN_W-1:0]        num_reg;
    logic [SPAN_W-1:0]        num_next;
    logic [SPAN_W-1:0]        den_reg;
    logic [SPAN_W-1:0]        den_next;
    logic [DIVD_W-1:0]        dividend_reg;
    logic [DIVD_W-1:0]        dividend_next;
    logic [DIVD_W-1:0]        divisor_reg;
    logic [DIVD_W-1:0]        divisor_next;
    logic [QUO_W-1:0]         quo_reg;
    logic [QUO_W-1:0]         quo_next;
    logic [STEP_W-1:0]        step_reg;
    logic [STEP_W-1:0]        step_next;
    logic [DUTY_W-1:0]        duty_reg;
    logic [DUTY_W-1:0]        duty_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    result_t                  out_reg;
    result_t                  out_next;
    logic signed [TEMP_W:0]   num_wide;
    logic signed [TEMP_W:0]   den_wide;
    logic                     fits;
    logic                     out_free;

    assign num_wide = {head.peak[TEMP_W-1], head.peak} - {temp_low[TEMP_W-1], temp_low};
    assign den_wide = {temp_high[TEMP_W-1], temp_high} - {temp_low[TEMP_W-1], temp_low};
    assign fits     = (dividend_reg >= divisor_reg);
    assign out_free = !out_valid_reg || !result_stall;
    assign pop      = (state_reg == ST_IDLE) && head.valid;

    always_comb
    begin
        state_next     = state_reg;
        max_next       = max_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        dividend_next  = dividend_reg;
        divisor_next   = divisor_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        duty_next      = duty_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_next       = out_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    max_next = head.peak;
                    num_next = num_wide[SPAN_W-1:0];
                    den_next = den_wide[SPAN_W-1:0];
                    priority if (head.peak <= temp_low)
                    begin
                        duty_next  = DUTY_MIN;
                        state_next = ST_DONE;
                    end
                    else if (head.peak >= temp_high)
                    begin
                        duty_next  = DUTY_MAX;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                dividend_next = DIVD_W'(num_reg) * DIVD_W'(DUTY_SPAN);
                divisor_next  = {den_reg, {(QUO_W-1){1'b0}}, 1'b0} >> 1;
                quo_next      = '0;
                step_next     = STEP_W'(DIV_STEPS - 1);
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (fits)
                begin
                    dividend_next = dividend_reg - divisor_reg;
                end
                divisor_next = divisor_reg >> 1;
                quo_next     = {quo_reg[QUO_W-2:0], fits};
                step_next    = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    duty_next  = DUTY_MIN + DUTY_W'(quo_next);
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold the result until the output register frees up
                if (out_free)
                begin
                    out_next.duty_permille   = duty_reg;
                    out_next.max_temperature = max_reg;
                    out_valid_next           = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        max_reg      <= max_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        dividend_reg <= dividend_next;
        divisor_reg  <= divisor_next;
        quo_reg      <= quo_next;
        step_reg     <= step_next;
        duty_reg     <= duty_next;
        out_reg      <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.duty_permille >= DUTY_MIN)
                          && (out_reg.duty_permille <= DUTY_MAX))
        else $error("duty outside 200..1000");

    a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> ({1'b0, dividend_reg} < {divisor_reg, 1'b0}))
        else $error("divider remainder out of bounds");

    a_full_duty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.duty_permille == DUTY_MAX))
            |-> (out_reg.max_temperature >= temp_high))
        else $error("full duty below high threshold");

endmodule

/* sv/fan_duty_from_max_temperature.sv */
// Flow: a frame's last sample pushes its maximum into the queue; the back part
// pops it, clamps the duty to 200 or 1000 or interpolates it with a 10-step
// divider, and registers the result. Samples are taken one per cycle unless the
// 2-entry queue of maxima is full; the back part takes a frame only when idle.
// Reset: running maximum -4368, thresholds 640 and 1280, no result pending.
// Top level; depends on fdmt_pkg, fdmt_front, fdmt_queue and fdmt_back.
module fan_duty_from_max_temperature
    import fdmt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  sample_t           sample,
    output logic              result_valid,
    input  logic              result_stall,
    output result_t           result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [0:0]        cfg_index,
    input  logic [TEMP_W-1:0] cfg_data
);

    logic signed [TEMP_W-1:0] temp_low_reg;
    logic signed [TEMP_W-1:0] temp_high_reg;
    frame_max_t               push;
    frame_max_t               head;
    logic                     pop;
    logic                     full;

    assign cfg_ready    = 1'b1;
    assign sample_stall = full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_low_reg  <= LOW_RESET;
            temp_high_reg <= HIGH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TEMP_LOW:  temp_low_reg  <= cfg_data;
                REG_TEMP_HIGH: temp_high_reg <= cfg_data;
            endcase
        end
    end

    fdmt_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .push         (push)
    );

    fdmt_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .full  (full)
    );

    fdmt_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .temp_low     (temp_low_reg),
        .temp_high    (temp_high_reg),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
